### sv/image_convolution_clamp_edge_top_defines.svh
// assertion helpers shared by the top level
`ifndef IMAGE_CONVOLUTION_CLAMP_EDGE_TOP_DEFINES_SVH
`define IMAGE_CONVOLUTION_CLAMP_EDGE_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define ICCE_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define ICCE_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/icce_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package icce_pkg;

    localparam int MAX_KERNEL_DIM = 7;
    localparam int MAX_WIDTH      = 2048;
    localparam int MAX_HEIGHT     = 4096;
    localparam int COEF_FRAC_BITS = 12;

    localparam int RING_ROWS = MAX_KERNEL_DIM + 1;
    localparam int TAPS      = MAX_KERNEL_DIM * MAX_KERNEL_DIM;
    localparam int HALF_MAX  = MAX_KERNEL_DIM / 2;
    localparam int ROW_LEAD  = RING_ROWS - 1 - HALF_MAX;

    localparam int COL_W  = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W  = $clog2(MAX_HEIGHT + 1);
    localparam int SLOT_W = $clog2(RING_ROWS);
    localparam int TAP_W  = $clog2(TAPS);
    localparam int HALF_W = $clog2(HALF_MAX + 1);
    localparam int KDIM_W = HALF_W + 1;

    localparam int LS_DEPTH = RING_ROWS * MAX_WIDTH;
    localparam int LS_AW    = $clog2(LS_DEPTH);

    localparam int COEF_W = 18;
    localparam int PIX_W  = 32;
    localparam int PROD_W = 9 + COEF_W;
    localparam int ACC_W  = PROD_W + $clog2(TAPS);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic [1:0] OP_COEF  = 2'd0;
    localparam logic [1:0] OP_PIXEL = 2'd1;
    localparam logic [1:0] OP_DRAIN = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_COLUMNS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_ROWS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_ENABLED  = 3'd4;

    typedef struct packed {
        logic [COL_W-1:0]  width;
        logic [ROW_W-1:0]  height;
        logic [HALF_W-1:0] half_cols;
        logic [HALF_W-1:0] half_rows;
        logic              alpha;
    } geom_t;

    typedef struct packed {
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic [SLOT_W-1:0] start_slot;
        logic              last;
        logic              frame;
    } job_t;

    typedef struct packed {
        logic             en;
        logic [LS_AW-1:0] addr;
        logic [PIX_W-1:0] data;
    } pix_wr_t;

    typedef struct packed {
        logic                     en;
        logic [TAP_W-1:0]         addr;
        logic signed [COEF_W-1:0] data;
    } coef_wr_t;

    typedef struct packed {
        logic             busy;
        logic [ROW_W-1:0] row;
        logic             frame;
    } pend_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_RUN,
        BK_FLUSH
    } back_state_t;

    function automatic logic [LS_AW-1:0] ls_addr(input logic [SLOT_W-1:0] slot,
                                                 input logic [COL_W-1:0] col);
        return LS_AW'(int'(slot) * MAX_WIDTH + int'(col));
    endfunction

endpackage
`default_nettype wire

### sv/icce_front.sv
`timescale 1ns / 1ps
`default_nettype none
module icce_front (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             s_valid,
    output logic                            s_ready,
    input  wire  [1:0]                      s_operation,
    input  wire  [5:0]                      s_coef_index,
    input  wire  signed [17:0]              s_coef_value,
    input  wire  [7:0]                      s_in_red,
    input  wire  [7:0]                      s_in_green,
    input  wire  [7:0]                      s_in_blue,
    input  wire  [7:0]                      s_in_alpha,
    input  wire                             cfg_wr_en,
    input  wire  [icce_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire  [icce_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire                             queue_full,
    input  icce_pkg::pend_t                 pend,
    output logic                            job_push,
    output icce_pkg::job_t                  job,
    output icce_pkg::pix_wr_t               pix_wr,
    output icce_pkg::coef_wr_t              coef_wr,
    output icce_pkg::geom_t                 geom
);
    import icce_pkg::*;

    logic [11:0] width_reg;
    logic [12:0] height_reg;
    logic [2:0]  kcols_reg;
    logic [2:0]  krows_reg;
    logic        alpha_reg;

    logic [COL_W-1:0]  in_col_reg, in_col_next, out_col_reg, out_col_next;
    logic [ROW_W-1:0]  in_row_reg, in_row_next, out_row_reg, out_row_next;
    logic [SLOT_W-1:0] in_slot_reg, in_slot_next, out_slot_reg, out_slot_next;
    logic              in_done_reg, in_done_next, frame_reg, frame_next;

    logic [COL_W-1:0]  eff_w, col_inc, need_col;
    logic [ROW_W-1:0]  eff_h, row_inc, need_row;
    logic [HALF_W-1:0] mx, my;
    logic [SLOT_W-1:0] start_slot;
    logic accept, is_pix, pix_write, stall_pix, ready_out, emit, last;

    function automatic logic [HALF_W-1:0] half_span(input logic [2:0] r);
        logic [2:0] m;
        m = (r | 3'd1) >> 1;
        if (int'(m) > HALF_MAX) m = 3'(HALF_MAX);
        return HALF_W'(m);
    endfunction

    always_comb begin
        eff_w = COL_W'(width_reg);
        if (width_reg == '0) eff_w = COL_W'(1);
        else if (int'(width_reg) > MAX_WIDTH) eff_w = COL_W'(MAX_WIDTH);
        eff_h = ROW_W'(height_reg);
        if (height_reg == '0) eff_h = ROW_W'(1);
        else if (int'(height_reg) > MAX_HEIGHT) eff_h = ROW_W'(MAX_HEIGHT);
        mx = half_span(kcols_reg);
        my = half_span(krows_reg);
    end

    assign geom = '{width: eff_w, height: eff_h, half_cols: mx, half_rows: my,
                    alpha: alpha_reg};

    assign is_pix    = (s_operation == OP_PIXEL);
    assign pix_write = is_pix && !in_done_reg;
    // keep the ring slot being written clear of rows the back end still reads
    assign stall_pix = pix_write && pend.busy &&
                       (pend.frame != frame_reg ||
                        int'(in_row_reg) > int'(pend.row) + ROW_LEAD);
    assign s_ready   = !queue_full && !stall_pix &&
                       !(s_operation == OP_COEF && pend.busy);
    assign accept    = s_valid && s_ready;

    assign col_inc = in_col_reg + 1'b1;
    assign row_inc = in_row_reg + 1'b1;

    always_comb begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        in_slot_next = in_slot_reg;
        in_done_next = in_done_reg;
        if (pix_write) begin
            if (col_inc >= eff_w) begin
                in_col_next  = '0;
                in_row_next  = row_inc;
                in_slot_next = (int'(in_slot_reg) == RING_ROWS - 1) ? '0 : in_slot_reg + 1'b1;
                if (row_inc >= eff_h) in_done_next = 1'b1;
            end else begin
                in_col_next = col_inc;
            end
        end
    end

    always_comb begin
        need_row = out_row_reg + ROW_W'(my);
        if (need_row > eff_h - 1'b1) need_row = eff_h - 1'b1;
        need_col = out_col_reg + COL_W'(mx);
        if (need_col > eff_w - 1'b1) need_col = eff_w - 1'b1;
        ready_out = in_done_next || (in_row_next > need_row) ||
                    (in_row_next == need_row && in_col_next > need_col);
        emit = (is_pix || s_operation == OP_DRAIN) && ready_out &&
               (out_row_reg < eff_h) && (out_col_reg < eff_w);
        last = (out_row_reg == eff_h - 1'b1) && (out_col_reg == eff_w - 1'b1);
    end

    always_comb begin
        start_slot = '0;
        if (out_row_reg >= ROW_W'(my)) begin
            if (out_slot_reg >= SLOT_W'(my)) start_slot = out_slot_reg - SLOT_W'(my);
            else start_slot = SLOT_W'(int'(out_slot_reg) + RING_ROWS - int'(my));
        end
    end

    assign job_push = accept && emit;
    assign job = '{col: out_col_reg, row: out_row_reg, start_slot: start_slot,
                   last: last, frame: frame_reg};

    assign pix_wr = '{en: accept && pix_write,
                      addr: ls_addr(in_slot_reg, in_col_reg),
                      data: {s_in_alpha, s_in_blue, s_in_green, s_in_red}};
    assign coef_wr = '{en: accept && s_operation == OP_COEF && int'(s_coef_index) < TAPS,
                       addr: TAP_W'(s_coef_index), data: s_coef_value};

    always_comb begin
        out_col_next  = out_col_reg;
        out_row_next  = out_row_reg;
        out_slot_next = out_slot_reg;
        frame_next    = frame_reg;
        if (job_push && !last) begin
            if (out_col_reg + 1'b1 >= eff_w) begin
                out_col_next  = '0;
                out_row_next  = out_row_reg + 1'b1;
                out_slot_next = (int'(out_slot_reg) == RING_ROWS - 1) ? '0
                                                                     : out_slot_reg + 1'b1;
            end else begin
                out_col_next = out_col_reg + 1'b1;
            end
        end
        if (job_push && last) frame_next = !frame_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg    <= 12'd640;
            height_reg   <= 13'd480;
            kcols_reg    <= 3'd3;
            krows_reg    <= 3'd3;
            alpha_reg    <= 1'b1;
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            in_slot_reg  <= '0;
            in_done_reg  <= 1'b0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            out_slot_reg <= '0;
            frame_reg    <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:    width_reg  <= cfg_data[11:0];
                REG_IMAGE_HEIGHT:   height_reg <= cfg_data[12:0];
                REG_KERNEL_COLUMNS: kcols_reg  <= cfg_data[2:0];
                REG_KERNEL_ROWS:    krows_reg  <= cfg_data[2:0];
                REG_ALPHA_ENABLED:  alpha_reg  <= cfg_data[0];
                default: ;
            endcase
            if (cfg_index inside {REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT,
                                  REG_KERNEL_COLUMNS, REG_KERNEL_ROWS}) begin
                in_col_reg   <= '0;
                in_row_reg   <= '0;
                in_slot_reg  <= '0;
                in_done_reg  <= 1'b0;
                out_col_reg  <= '0;
                out_row_reg  <= '0;
                out_slot_reg <= '0;
            end
        end else if (accept) begin
            frame_reg <= frame_next;
            if (job_push && last) begin
                // frame complete: everything back to the origin
                in_col_reg   <= '0;
                in_row_reg   <= '0;
                in_slot_reg  <= '0;
                in_done_reg  <= 1'b0;
                out_col_reg  <= '0;
                out_row_reg  <= '0;
                out_slot_reg <= '0;
            end else begin
                in_col_reg   <= in_col_next;
                in_row_reg   <= in_row_next;
                in_slot_reg  <= in_slot_next;
                in_done_reg  <= in_done_next;
                out_col_reg  <= out_col_next;
                out_row_reg  <= out_row_next;
                out_slot_reg <= out_slot_next;
            end
        end
    end

endmodule
`default_nettype wire

### sv/icce_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module icce_queue (
    input  wire             aclk,
    input  wire             aresetn,
    input  wire             push,
    input  icce_pkg::job_t  push_job,
    input  wire             pop,
    output logic            full,
    output logic            empty,
    output icce_pkg::job_t  head
);
    import icce_pkg::*;

    job_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    assign full  = (int'(count_reg) == QUEUE_DEPTH);
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) entry_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop) count_reg <= count_reg + 1'b1;
            else if (pop && !push) count_reg <= count_reg - 1'b1;
        end
    end

endmodule
`default_nettype wire

### sv/icce_back.sv
`timescale 1ns / 1ps
`default_nettype none
module icce_back (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  icce_pkg::geom_t     geom,
    input  icce_pkg::pix_wr_t   pix_wr,
    input  icce_pkg::coef_wr_t  coef_wr,
    input  wire                 job_valid,
    input  icce_pkg::job_t      job_head,
    output logic                job_pop,
    output icce_pkg::pend_t     pend,
    output logic                m_valid,
    input  wire                 m_ready,
    output logic [7:0]          m_out_red,
    output logic [7:0]          m_out_green,
    output logic [7:0]          m_out_blue,
    output logic [7:0]          m_out_alpha,
    output logic [10:0]         m_out_column,
    output logic [11:0]         m_out_row,
    output logic                m_frame_end
);
    import icce_pkg::*;

    logic [PIX_W-1:0]         line_store [LS_DEPTH];
    logic signed [COEF_W-1:0] coef_mem [TAPS];
    logic [TAPS-1:0]          coef_valid_reg;

    back_state_t state_reg, state_next;
    job_t        job_reg;
    logic [KDIM_W-1:0] kx_reg, ky_reg;
    logic [TAP_W-1:0]  tap_reg;
    logic [SLOT_W-1:0] slot_reg;

    logic issue, load_out, out_free, tap_last, col_last;
    logic signed [COL_W+1:0] craw;
    logic signed [ROW_W+1:0] rraw;
    logic [COL_W-1:0] rd_col;

    logic                     s1_valid_reg, s1_last_reg, coef_ok_q;
    logic [PIX_W-1:0]         pix_q;
    logic signed [COEF_W-1:0] coef_q;
    logic                     s2_valid_reg, s2_last_reg;
    logic signed [PROD_W-1:0] prod_reg [4];
    logic signed [ACC_W-1:0]  acc_reg [4];
    logic                     acc_done_reg;
    logic                     m_valid_reg;

    function automatic logic [7:0] finish(input logic signed [ACC_W-1:0] s);
        logic signed [ACC_W-1:0] q;
        q = s >>> COEF_FRAC_BITS;
        if (s <= 0) return 8'd0;
        if (q > 255) return 8'd255;
        return q[7:0];
    endfunction

    // tap position with the edge replicated
    always_comb begin
        craw = $signed((COL_W+2)'(job_reg.col)) + $signed((COL_W+2)'(kx_reg))
             - $signed((COL_W+2)'(geom.half_cols));
        rraw = $signed((ROW_W+2)'(job_reg.row)) + $signed((ROW_W+2)'(ky_reg))
             - $signed((ROW_W+2)'(geom.half_rows));
        if (craw < 0) rd_col = '0;
        else if (craw >= $signed((COL_W+2)'(geom.width))) rd_col = geom.width - 1'b1;
        else rd_col = COL_W'(craw);
        col_last = (kx_reg == {geom.half_cols, 1'b0});
        tap_last = col_last && (ky_reg == {geom.half_rows, 1'b0});
    end

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:  if (job_valid) state_next = BK_RUN;
            BK_RUN:   if (tap_last) state_next = BK_FLUSH;
            BK_FLUSH: if (acc_done_reg && out_free) state_next = BK_IDLE;
            default:  state_next = BK_IDLE;
        endcase
    end

    always_comb begin
        job_pop  = 1'b0;
        issue    = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            BK_IDLE:  job_pop = job_valid;
            BK_RUN:   issue = 1'b1;
            BK_FLUSH: load_out = acc_done_reg && out_free;
            default: ;
        endcase
    end

    assign pend.busy  = (state_reg != BK_IDLE) || job_valid;
    assign pend.row   = (state_reg != BK_IDLE) ? job_reg.row : job_head.row;
    assign pend.frame = (state_reg != BK_IDLE) ? job_reg.frame : job_head.frame;

    always_ff @(posedge aclk) begin
        if (pix_wr.en) line_store[pix_wr.addr] <= pix_wr.data;
        if (issue) pix_q <= line_store[ls_addr(slot_reg, rd_col)];
    end

    always_ff @(posedge aclk) begin
        if (coef_wr.en) coef_mem[coef_wr.addr] <= coef_wr.data;
        if (issue) begin
            coef_q    <= coef_mem[tap_reg];
            coef_ok_q <= coef_valid_reg[tap_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_valid_reg <= '0;
        end else if (coef_wr.en) begin
            coef_valid_reg[coef_wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (job_pop) begin
            job_reg  <= job_head;
            kx_reg   <= '0;
            ky_reg   <= '0;
            tap_reg  <= '0;
            slot_reg <= job_head.start_slot;
        end else if (issue) begin
            tap_reg <= tap_reg + 1'b1;
            if (col_last) begin
                kx_reg <= '0;
                ky_reg <= ky_reg + 1'b1;
                // next row moves only while inside the frame
                if (rraw >= 0 && rraw + 1 < $signed((ROW_W+2)'(geom.height)))
                    slot_reg <= (int'(slot_reg) == RING_ROWS - 1) ? '0 : slot_reg + 1'b1;
            end else begin
                kx_reg <= kx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int ch = 0; ch < 4; ch++) begin
            prod_reg[ch] <= $signed({1'b0, pix_q[8*ch +: 8]}) *
                            (coef_ok_q ? coef_q : $signed(COEF_W'(0)));
        end
    end

    always_ff @(posedge aclk) begin
        for (int ch = 0; ch < 4; ch++) begin
            if (job_pop) acc_reg[ch] <= '0;
            else if (s2_valid_reg)
                acc_reg[ch] <= acc_reg[ch] +
                               $signed({{(ACC_W-PROD_W){prod_reg[ch][PROD_W-1]}}, prod_reg[ch]});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= BK_IDLE;
            s1_valid_reg <= 1'b0;
            s1_last_reg  <= 1'b0;
            s2_valid_reg <= 1'b0;
            s2_last_reg  <= 1'b0;
            acc_done_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            s1_valid_reg <= issue;
            s1_last_reg  <= issue && tap_last;
            s2_valid_reg <= s1_valid_reg;
            s2_last_reg  <= s1_last_reg;
            if (job_pop) acc_done_reg <= 1'b0;
            else if (s2_valid_reg && s2_last_reg) acc_done_reg <= 1'b1;
            if (load_out) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_out_red    <= finish(acc_reg[0]);
            m_out_green  <= finish(acc_reg[1]);
            m_out_blue   <= finish(acc_reg[2]);
            m_out_alpha  <= geom.alpha ? finish(acc_reg[3]) : 8'd0;
            m_out_column <= job_reg.col[10:0];
            m_out_row    <= job_reg.row[11:0];
            m_frame_end  <= job_reg.last;
        end
    end

    assign m_valid = m_valid_reg;

endmodule
`default_nettype wire

### sv/image_convolution_clamp_edge_top.sv
// channel | direction | handshake          | payload
// s_      | in        | s_valid / s_ready  | operation, coefficient, rgba pixel
// m_      | out       | m_valid / m_ready  | rgba result, column, row, frame_end
// cfg_    | in        | cfg_wr_en          | cfg_index, cfg_data
//
// the front end takes one item per cycle while the 4-entry job queue has room and no
// wait below holds; each emitted pixel costs (2*mx+1)*(2*my+1) taps in the back end,
// one tap per cycle through the single line store read port and the product pipeline
// reset clears counters and coefficient valid bits at once; no clearing pass
// coefficient loads wait for the back end to go idle; pixels wait while their
// ring row is still needed by a pending output
`timescale 1ns / 1ps
`default_nettype none
`include "image_convolution_clamp_edge_top_defines.svh"
module image_convolution_clamp_edge_top (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             s_valid,
    output logic                            s_ready,
    input  wire  [1:0]                      s_operation,
    input  wire  [5:0]                      s_coef_index,
    input  wire  signed [17:0]              s_coef_value,
    input  wire  [7:0]                      s_in_red,
    input  wire  [7:0]                      s_in_green,
    input  wire  [7:0]                      s_in_blue,
    input  wire  [7:0]                      s_in_alpha,
    output logic                            m_valid,
    input  wire                             m_ready,
    output logic [7:0]                      m_out_red,
    output logic [7:0]                      m_out_green,
    output logic [7:0]                      m_out_blue,
    output logic [7:0]                      m_out_alpha,
    output logic [10:0]                     m_out_column,
    output logic [11:0]                     m_out_row,
    output logic                            m_frame_end,
    input  wire                             cfg_wr_en,
    input  wire  [icce_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire  [icce_pkg::CFG_DATA_W-1:0] cfg_data
);
    import icce_pkg::*;

    logic     queue_full, queue_empty, job_push, job_pop;
    job_t     job_in, job_head;
    pend_t    pend;
    pix_wr_t  pix_wr;
    coef_wr_t coef_wr;
    geom_t    geom;

    icce_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_operation(s_operation),
        .s_coef_index(s_coef_index), .s_coef_value(s_coef_value),
        .s_in_red(s_in_red), .s_in_green(s_in_green),
        .s_in_blue(s_in_blue), .s_in_alpha(s_in_alpha),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .queue_full(queue_full), .pend(pend),
        .job_push(job_push), .job(job_in),
        .pix_wr(pix_wr), .coef_wr(coef_wr), .geom(geom)
    );

    icce_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .push(job_push), .push_job(job_in), .pop(job_pop),
        .full(queue_full), .empty(queue_empty), .head(job_head)
    );

    icce_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .geom(geom), .pix_wr(pix_wr), .coef_wr(coef_wr),
        .job_valid(!queue_empty), .job_head(job_head), .job_pop(job_pop),
        .pend(pend),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_out_red(m_out_red), .m_out_green(m_out_green),
        .m_out_blue(m_out_blue), .m_out_alpha(m_out_alpha),
        .m_out_column(m_out_column), .m_out_row(m_out_row),
        .m_frame_end(m_frame_end)
    );

    `ICCE_ASSERT_NOW(a_coef_load_idle, aclk, aresetn, coef_wr.en, !pend.busy, "coefficient load while busy")
    `ICCE_ASSERT_NOW(a_push_has_room, aclk, aresetn, job_push, !queue_full, "job pushed into full queue")
    `ICCE_ASSERT_NOW(a_pop_has_job, aclk, aresetn, job_pop, !queue_empty, "job popped from empty queue")
    `ICCE_ASSERT_NEXT(a_pop_makes_busy, aclk, aresetn, job_pop, pend.busy, "back end idle after pop")

endmodule
`default_nettype wire

### sim/image_convolution_clamp_edge_top_tb.sv
`timescale 1ns / 1ps
module image_convolution_clamp_edge_top_tb;
    import icce_pkg::*;

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [10:0] column;
        logic [11:0] row;
        logic        frame_end;
    } conv_pix_t;

    typedef struct packed {
        logic [1:0]         op;
        logic [5:0]         idx;
        logic signed [17:0] val;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic [7:0]         alpha;
    } stream_item_t;

    typedef enum logic [1:0] {
        CHK_NONE,
        CHK_TYPED,
        CHK_MODEL
    } chk_kind_t;

    typedef struct packed {
        stream_item_t item;
        chk_kind_t    kind;
        conv_pix_t    pix;
    } dir_row_t;

    localparam int DIR_ROWS = 13;
    localparam int RX_HOLD  = 600;
    localparam int SETTLE   = 400;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [1:0]            s_operation = '0;
    logic [5:0]            s_coef_index = '0;
    logic signed [17:0]    s_coef_value = '0;
    logic [7:0]            s_in_red = '0;
    logic [7:0]            s_in_green = '0;
    logic [7:0]            s_in_blue = '0;
    logic [7:0]            s_in_alpha = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [7:0]            m_out_red;
    logic [7:0]            m_out_green;
    logic [7:0]            m_out_blue;
    logic [7:0]            m_out_alpha;
    logic [10:0]           m_out_column;
    logic [11:0]           m_out_row;
    logic                  m_frame_end;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    image_convolution_clamp_edge_top u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_operation(s_operation), .s_coef_index(s_coef_index),
        .s_coef_value(s_coef_value), .s_in_red(s_in_red), .s_in_green(s_in_green),
        .s_in_blue(s_in_blue), .s_in_alpha(s_in_alpha),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_out_red(m_out_red), .m_out_green(m_out_green), .m_out_blue(m_out_blue),
        .m_out_alpha(m_out_alpha), .m_out_column(m_out_column), .m_out_row(m_out_row),
        .m_frame_end(m_frame_end),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 aclk = ~aclk;

    // predictor state
    int unsigned        cur_width = 640, cur_height = 480;
    int unsigned        cur_kcols = 3, cur_krows = 3, cur_alpha = 1;
    logic signed [17:0] coef_tab [TAPS];
    logic [31:0]        ring_mem [RING_ROWS*MAX_WIDTH];
    int                 in_col, in_row, out_col, out_row;
    bit                 in_done;

    conv_pix_t pending_pix [$];
    int        errors = 0;
    bit        tx_burst = 1'b0;
    bit        rx_burst = 1'b0;
    bit        rx_hold_req = 1'b0;
    int        items_sent = 0;

    function automatic int eff_width();
        if (cur_width < 1) return 1;
        if (cur_width > MAX_WIDTH) return MAX_WIDTH;
        return cur_width;
    endfunction

    function automatic int eff_height();
        if (cur_height < 1) return 1;
        if (cur_height > MAX_HEIGHT) return MAX_HEIGHT;
        return cur_height;
    endfunction

    function automatic int half_span(int unsigned reg_val);
        int m;
        m = (reg_val | 1) >> 1;
        return (m > HALF_MAX) ? HALF_MAX : m;
    endfunction

    function automatic logic [7:0] clamp_chan(longint sum);
        longint q;
        if (sum <= 0) return 8'd0;
        q = sum >>> COEF_FRAC_BITS;
        return (q > 255) ? 8'd255 : 8'(q);
    endfunction

    function automatic void restart_frame();
        in_col = 0;
        in_row = 0;
        out_col = 0;
        out_row = 0;
        in_done = 1'b0;
    endfunction

    function automatic void apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_IMAGE_WIDTH: begin
                cur_width = val[11:0];
                restart_frame();
            end
            REG_IMAGE_HEIGHT: begin
                cur_height = val[12:0];
                restart_frame();
            end
            REG_KERNEL_COLUMNS: begin
                cur_kcols = val[2:0];
                restart_frame();
            end
            REG_KERNEL_ROWS: begin
                cur_krows = val[2:0];
                restart_frame();
            end
            REG_ALPHA_ENABLED: cur_alpha = val[0];
            default: ;
        endcase
    endfunction

    function automatic bit conv_emit(output conv_pix_t o);
        int w, h, mx, my, kc, need_r, need_c, r, c;
        longint sum [4];
        longint k;
        logic [31:0] p;
        o = '0;
        w = eff_width();
        h = eff_height();
        mx = half_span(cur_kcols);
        my = half_span(cur_krows);
        kc = 2 * mx + 1;
        if (out_row >= h || out_col >= w) return 1'b0;
        if (!in_done) begin
            need_r = (out_row + my > h - 1) ? h - 1 : out_row + my;
            need_c = (out_col + mx > w - 1) ? w - 1 : out_col + mx;
            if (!(in_row > need_r || (in_row == need_r && in_col > need_c))) return 1'b0;
        end
        for (int ch = 0; ch < 4; ch++) sum[ch] = 0;
        for (int dy = -my; dy <= my; dy++) begin
            r = out_row + dy;
            if (r < 0) r = 0;
            if (r >= h) r = h - 1;
            for (int dx = -mx; dx <= mx; dx++) begin
                c = out_col + dx;
                if (c < 0) c = 0;
                if (c >= w) c = w - 1;
                p = ring_mem[(r % RING_ROWS) * MAX_WIDTH + c];
                k = coef_tab[((dy + my) * kc + dx + mx) % TAPS];
                for (int ch = 0; ch < 4; ch++)
                    sum[ch] += longint'({56'd0, p[8*ch +: 8]}) * k;
            end
        end
        o.red = clamp_chan(sum[0]);
        o.green = clamp_chan(sum[1]);
        o.blue = clamp_chan(sum[2]);
        o.alpha = cur_alpha[0] ? clamp_chan(sum[3]) : 8'd0;
        o.column = 11'(out_col);
        o.row = 12'(out_row);
        o.frame_end = (out_row == h - 1) && (out_col == w - 1);
        if (o.frame_end) begin
            restart_frame();
        end else begin
            out_col++;
            if (out_col >= w) begin
                out_col = 0;
                out_row++;
            end
        end
        return 1'b1;
    endfunction

    function automatic bit conv_predict(stream_item_t it, output conv_pix_t o);
        int w, h;
        o = '0;
        w = eff_width();
        h = eff_height();
        case (it.op)
            OP_COEF: begin
                if (it.idx < TAPS) coef_tab[it.idx] = it.val;
                return 1'b0;
            end
            OP_PIXEL: begin
                if (!in_done) begin
                    if (in_row < h && in_col < w)
                        ring_mem[(in_row % RING_ROWS) * MAX_WIDTH + in_col] =
                            {it.alpha, it.blue, it.green, it.red};
                    in_col++;
                    if (in_col >= w) begin
                        in_col = 0;
                        in_row++;
                        if (in_row >= h) in_done = 1'b1;
                    end
                end
                return conv_emit(o);
            end
            OP_DRAIN: return conv_emit(o);
            default: return 1'b0;
        endcase
    endfunction

    function automatic dir_row_t dir_row(logic [1:0] op, logic [5:0] idx, logic signed [17:0] val,
                                         logic [31:0] rgba, chk_kind_t kind, conv_pix_t pix);
        dir_row_t d;
        d.item = '{op, idx, val, rgba[31:24], rgba[23:16], rgba[15:8], rgba[7:0]};
        d.kind = kind;
        d.pix = pix;
        return d;
    endfunction

    task automatic report_mismatch(string what, int exp_val, int got_val);
        $display("mismatch %s: expected %0d got %0d at %0t", what, exp_val, got_val, $realtime);
        errors++;
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        apply_cfg(idx, val);
        @(posedge aclk);
    endtask

    task automatic wait_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_pix.size() != 0) @(posedge aclk);
    endtask

    task automatic set_geometry(int w, int h, int kcols, int krows, int alpha);
        wait_results();
        repeat (SETTLE) @(posedge aclk);
        cfg_write(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
        cfg_write(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
        cfg_write(REG_KERNEL_COLUMNS, CFG_DATA_W'(kcols));
        cfg_write(REG_KERNEL_ROWS, CFG_DATA_W'(krows));
        cfg_write(REG_ALPHA_ENABLED, CFG_DATA_W'(alpha));
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_item(stream_item_t it, chk_kind_t kind, conv_pix_t typed);
        int gap;
        conv_pix_t o;
        bit has;
        gap = tx_burst ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_operation <= it.op;
        s_coef_index <= it.idx;
        s_coef_value <= it.val;
        s_in_red <= it.red;
        s_in_green <= it.green;
        s_in_blue <= it.blue;
        s_in_alpha <= it.alpha;
        do @(posedge aclk); while (!s_ready);
        has = conv_predict(it, o);
        if (kind == CHK_TYPED) pending_pix.push_back(typed);
        else if (kind == CHK_MODEL && has) pending_pix.push_back(o);
        items_sent++;
    endtask

    function automatic stream_item_t rand_item(logic [1:0] op);
        stream_item_t it;
        it.op = op;
        it.idx = 6'($urandom_range(0, 63));
        it.val = ($urandom_range(0, 3) == 0) ? 18'($urandom)
                                             : 18'(int'($urandom_range(0, 6000)) - 1500);
        it.red = 8'($urandom);
        it.green = 8'($urandom);
        it.blue = 8'($urandom);
        it.alpha = 8'($urandom);
        return it;
    endfunction

    task automatic load_coefs(bit identity);
        stream_item_t it;
        for (int i = 0; i < TAPS; i++) begin
            it = rand_item(OP_COEF);
            it.idx = 6'(i);
            if (identity) it.val = (i == 0) ? 18'sd4096 : 18'sd0;
            send_item(it, CHK_MODEL, '0);
        end
    endtask

    // pixels of a frame, noise if noisy, drains to its end; cut_short stops early
    task automatic run_frame(bit noisy, bit cut_short);
        int npix, stop_at;
        stream_item_t it;
        npix = eff_width() * eff_height();
        stop_at = cut_short ? $urandom_range(1, npix) : npix;
        for (int i = 0; i < stop_at; i++) begin
            if (noisy && $urandom_range(0, 9) == 0) begin
                case ($urandom_range(0, 3))
                    0: it = rand_item(OP_DRAIN);
                    1: it = rand_item(2'd3);
                    2: begin
                        it = rand_item(OP_COEF);
                        it.idx = 6'($urandom_range(TAPS, 63));
                    end
                    default: begin
                        it = rand_item(OP_COEF);
                        it.idx = 6'($urandom_range(0, TAPS - 1));
                    end
                endcase
                send_item(it, CHK_MODEL, '0);
            end
            send_item(rand_item(OP_PIXEL), CHK_MODEL, '0);
        end
        if (cut_short) return;
        while (in_done) begin
            // a pixel while outputs are pending acts as a drain
            it = rand_item(($urandom_range(0, 4) == 0) ? OP_PIXEL : OP_DRAIN);
            send_item(it, CHK_MODEL, '0);
        end
    endtask

    dir_row_t dir_tab [DIR_ROWS];

    initial begin
        dir_tab[0]  = dir_row(OP_DRAIN, 6'd0, 18'sd0, 32'h0, CHK_NONE, '0);
        dir_tab[1]  = dir_row(2'd3, 6'd5, 18'sd7, 32'hffffffff, CHK_NONE, '0);
        dir_tab[2]  = dir_row(OP_COEF, 6'd63, 18'sd5, 32'h0, CHK_NONE, '0);
        dir_tab[3]  = dir_row(OP_COEF, 6'd0, 18'sd4096, 32'h0, CHK_NONE, '0);
        dir_tab[4]  = dir_row(OP_PIXEL, 6'd0, 18'sd0, 32'hff008007, CHK_TYPED,
                              '{8'd255, 8'd0, 8'd128, 8'd7, 11'd0, 12'd0, 1'b0});
        dir_tab[5]  = dir_row(OP_PIXEL, 6'd0, 18'sd0, 32'h01020304, CHK_TYPED,
                              '{8'd1, 8'd2, 8'd3, 8'd4, 11'd1, 12'd0, 1'b1});
        dir_tab[6]  = dir_row(OP_COEF, 6'd0, -18'sd131072, 32'h0, CHK_NONE, '0);
        dir_tab[7]  = dir_row(OP_PIXEL, 6'd0, 18'sd0, 32'hffffffff, CHK_TYPED,
                              '{8'd0, 8'd0, 8'd0, 8'd0, 11'd0, 12'd0, 1'b0});
        dir_tab[8]  = dir_row(OP_COEF, 6'd0, 18'sd131071, 32'h0, CHK_NONE, '0);
        dir_tab[9]  = dir_row(OP_PIXEL, 6'd0, 18'sd0, 32'hff000100, CHK_TYPED,
                              '{8'd255, 8'd0, 8'd31, 8'd0, 11'd1, 12'd0, 1'b1});
        dir_tab[10] = dir_row(OP_COEF, 6'd48, -18'sd1, 32'h0, CHK_MODEL, '0);
        dir_tab[11] = dir_row(OP_PIXEL, 6'd0, 18'sd0, 32'h0, CHK_TYPED,
                              '{8'd0, 8'd0, 8'd0, 8'd0, 11'd0, 12'd0, 1'b0});
        dir_tab[12] = dir_row(OP_PIXEL, 6'd0, 18'sd0, 32'h80402010, CHK_TYPED,
                              '{8'd255, 8'd255, 8'd255, 8'd255, 11'd1, 12'd0, 1'b1});
        for (int i = 0; i < TAPS; i++) coef_tab[i] = '0;
        for (int i = 0; i < RING_ROWS * MAX_WIDTH; i++) ring_mem[i] = '0;
        restart_frame();

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        set_geometry(2, 1, 1, 1, 1);
        foreach (dir_tab[i]) send_item(dir_tab[i].item, dir_tab[i].kind, dir_tab[i].pix);

        // widest row with a single-tap kernel, even kernel value zero
        // only the start of the frame; the next geometry write restarts it
        set_geometry(2048, 1, 0, 0, 0);
        tx_burst = 1'b1;
        load_coefs(1'b1);
        tx_burst = 1'b0;
        repeat (40) send_item(rand_item(OP_PIXEL), CHK_MODEL, '0);

        // tallest column, width saturating from zero, height from its top code
        set_geometry(0, 8191, 2, 7, 1);
        load_coefs(1'b0);
        tx_burst = 1'b1;
        repeat (40) send_item(rand_item(OP_PIXEL), CHK_MODEL, '0);
        tx_burst = 1'b0;

        for (int ph = 0; items_sent < 400 || ph < 3; ph++) begin
            set_geometry(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 9),
                         ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6),
                         $urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 1));
            tx_burst = ($urandom_range(0, 3) == 0);
            if (ph == 0 || $urandom_range(0, 1) == 0) load_coefs(1'b0);
            if (ph == 1) rx_hold_req = 1'b1;
            if (ph == 2) begin
                send_item(rand_item(OP_PIXEL), CHK_MODEL, '0);
                wait_results();
            end
            run_frame(1'b1, (ph > 2) && ($urandom_range(0, 6) == 0));
        end

        wait_results();
        repeat (SETTLE) @(posedge aclk);
        if (errors == 0 && pending_pix.size() == 0) begin
            $display("PASS image_convolution_clamp_edge_top");
        end else begin
            $display("FAIL image_convolution_clamp_edge_top");
        end
        $finish;
    end

    initial begin
        int n;
        int rx_count;
        rx_count = 0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (RX_HOLD) @(posedge aclk);
            end
            n = rx_burst ? 0 : $urandom_range(0, 19);
            if (n > 0) begin
                m_ready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            rx_count++;
            if (rx_count % 40 == 0) rx_burst = ($urandom_range(0, 3) == 0);
        end
    end

    // checks each result transfer against the oldest expected pixel
    always @(posedge aclk) begin
        conv_pix_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_pix.size() == 0) begin
                report_mismatch("unexpected result, column", -1, m_out_column);
            end else begin
                e = pending_pix.pop_front();
                if (m_out_red !== e.red) report_mismatch("red", e.red, m_out_red);
                if (m_out_green !== e.green) report_mismatch("green", e.green, m_out_green);
                if (m_out_blue !== e.blue) report_mismatch("blue", e.blue, m_out_blue);
                if (m_out_alpha !== e.alpha) report_mismatch("alpha", e.alpha, m_out_alpha);
                if (m_out_column !== e.column)
                    report_mismatch("column", e.column, m_out_column);
                if (m_out_row !== e.row) report_mismatch("row", e.row, m_out_row);
                if (m_frame_end !== e.frame_end)
                    report_mismatch("frame_end", e.frame_end, m_frame_end);
            end
        end
    end

    initial begin
        #20ms;
        $display("FAIL image_convolution_clamp_edge_top");
        $finish;
    end

endmodule

### files.f
+incdir+sv
sv/icce_pkg.sv
sv/icce_front.sv
sv/icce_queue.sv
sv/icce_back.sv
sv/image_convolution_clamp_edge_top.sv
sim/image_convolution_clamp_edge_top_tb.sv
